FILE: hw/rtl/ease_in_out_arc_length_stepper_assert.svh
// assertion macros shared by the stepper rtl
// expects i_clk and i_rst_n in the including module
`ifndef EASE_IN_OUT_ARC_LENGTH_STEPPER_ASSERT_SVH
`define EASE_IN_OUT_ARC_LENGTH_STEPPER_ASSERT_SVH

// same-cycle implication
`define EALS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("eals assertion failed");

// next-cycle implication
`define EALS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eals assertion failed");

`endif

FILE: hw/rtl/eals_pkg.sv
// shared types and constants of the ease-in-out arc length stepper
// no dependencies
package eals_pkg;

    localparam int FRAC_W      = 16;
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = FRAC_W + 1;
    localparam int DT_W        = FRAC_W;
    localparam int TOTAL_W     = FRAC_W + 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int USER_W      = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 48;
    localparam int PROD_W      = 64;
    localparam int V0_W        = 2 * FRAC_W + 1;
    localparam int DEN_W       = TOTAL_W;
    localparam int REM_W       = DEN_W + 1;
    localparam int DIV_CNT_W   = $clog2(PROD_W) + 1;
    localparam int CRX_W       = LEN_W + 1;

    localparam logic [LEN_W-1:0]     ONE_Q    = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [PROD_W-1:0]    V0_NUM   = 64'd1 << (2 * FRAC_W + 1);
    localparam logic [PROD_W-1:0]    V0_CAP   = 64'd1 << (2 * FRAC_W);
    localparam logic [DIV_CNT_W-1:0] DIV_ITER = DIV_CNT_W'(PROD_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_END   = 3'd0,
        CFG_DECEL_START = 3'd1,
        CFG_TOTAL_TIME  = 3'd2,
        CFG_MOTION_EN   = 3'd3,
        CFG_LAST_ENTRY  = 3'd4
    } t_cfg_reg;

    typedef enum logic [USER_W-1:0] {
        ITEM_LOAD    = 2'd0,
        ITEM_TICK    = 2'd1,
        ITEM_RESTART = 2'd2
    } t_item_op;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESTART,
        OP_DIV_INC_START,
        OP_DIV_STEP,
        OP_TIME_UPDATE,
        OP_DIV_V0_START,
        OP_V0_TAKE,
        OP_MUL_SQ_START,
        OP_MUL_STEP,
        OP_MUL_V_START,
        OP_DIV_S_START,
        OP_S_CRUISE,
        OP_S_TAKE,
        OP_WALK_INIT,
        OP_WALK_INC,
        OP_OUT_LOAD
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC_DIV,
        S_V0_START,
        S_V0_DIV,
        S_PREP,
        S_MUL_SQ,
        S_MUL_V,
        S_S_DIV,
        S_WALK_INIT,
        S_WALK_CHK,
        S_WALK_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   div_done;
        logic   mul_done;
        t_phase phase;
        logic   walk_more;
        logic   entry_lt_s;
    } t_dp_stat;

endpackage

FILE: hw/rtl/eals_ram.sv
// generic single write port ram with registered read
// no dependencies
module eals_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/eals_ctrl.sv
// sequencer of the stepper: handshakes and datapath commands
// depends on eals_pkg and the assertion header
`include "ease_in_out_arc_length_stepper_assert.svh"

module eals_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [eals_pkg::USER_W-1:0]  i_in_user,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output eals_pkg::t_dp_op             o_op,
    input  eals_pkg::t_dp_stat           i_stat
);
    import eals_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   in_ready;

    assign in_ready    = (r_state == S_IDLE);
    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_op == OP_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_user)
                        ITEM_LOAD: begin
                            o_op = OP_LOAD;
                        end
                        ITEM_TICK: begin
                            o_op    = OP_DIV_INC_START;
                            n_state = S_INC_DIV;
                        end
                        ITEM_RESTART: begin
                            o_op = OP_RESTART;
                        end
                        default: ;
                    endcase
                end
            end
            S_INC_DIV: begin
                if (i_stat.div_done) begin
                    o_op    = OP_TIME_UPDATE;
                    n_state = S_V0_START;
                end else begin
                    o_op = OP_DIV_STEP;
                end
            end
            S_V0_START: begin
                if (i_stat.phase == PH_DONE) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_DIV_V0_START;
                    n_state = S_V0_DIV;
                end
            end
            S_V0_DIV: begin
                if (i_stat.div_done) begin
                    o_op    = OP_V0_TAKE;
                    n_state = S_PREP;
                end else begin
                    o_op = OP_DIV_STEP;
                end
            end
            S_PREP: begin
                if (i_stat.phase == PH_CRUISE) begin
                    o_op    = OP_MUL_V_START;
                    n_state = S_MUL_V;
                end else begin
                    o_op    = OP_MUL_SQ_START;
                    n_state = S_MUL_SQ;
                end
            end
            S_MUL_SQ: begin
                if (i_stat.mul_done) begin
                    o_op    = OP_MUL_V_START;
                    n_state = S_MUL_V;
                end else begin
                    o_op = OP_MUL_STEP;
                end
            end
            S_MUL_V: begin
                if (!i_stat.mul_done) begin
                    o_op = OP_MUL_STEP;
                end else if (i_stat.phase == PH_CRUISE) begin
                    o_op    = OP_S_CRUISE;
                    n_state = S_WALK_INIT;
                end else begin
                    o_op    = OP_DIV_S_START;
                    n_state = S_S_DIV;
                end
            end
            S_S_DIV: begin
                if (i_stat.div_done) begin
                    o_op    = OP_S_TAKE;
                    n_state = S_WALK_INIT;
                end else begin
                    o_op = OP_DIV_STEP;
                end
            end
            S_WALK_INIT: begin
                o_op    = OP_WALK_INIT;
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                n_state = i_stat.walk_more ? S_WALK_CMP : S_DONE;
            end
            S_WALK_CMP: begin
                if (i_stat.entry_lt_s) begin
                    o_op    = OP_WALK_INC;
                    n_state = S_WALK_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op    = OP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `EALS_ASSERT_NXT(a_tick_starts_div, i_in_valid && in_ready && i_in_user == ITEM_TICK, r_state == S_INC_DIV)
    `EALS_ASSERT_IMP(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE)
    `EALS_ASSERT_IMP(a_no_overwrite, r_out_valid && !i_out_ready, o_op != OP_OUT_LOAD)

endmodule

FILE: hw/rtl/eals_dp.sv
// datapath of the stepper: config, time, shared divider and multiplier, table walk
// depends on eals_pkg, eals_ram and the assertion header
`include "ease_in_out_arc_length_stepper_assert.svh"

module eals_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  eals_pkg::t_dp_op                 i_op,
    output eals_pkg::t_dp_stat               o_stat,
    input  logic                             i_cfg_wen,
    input  logic [eals_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [eals_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [eals_pkg::IN_DATA_W-1:0]   i_in_data,
    output logic [eals_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic [eals_pkg::USER_W-1:0]      o_out_user
);
    import eals_pkg::*;

    function automatic t_phase phase_of(input logic [LEN_W-1:0] t,
                                        input logic [FRAC_W-1:0] t1,
                                        input logic [FRAC_W-1:0] t2);
        if (t < {1'b0, t1}) begin
            return PH_ACCEL;
        end else if (t < {1'b0, t2}) begin
            return PH_CRUISE;
        end else if (t < ONE_Q) begin
            return PH_DECEL;
        end
        return PH_DONE;
    endfunction

    // configuration
    logic [FRAC_W-1:0]  r_accel_end;
    logic [FRAC_W-1:0]  r_decel_start;
    logic [TOTAL_W-1:0] r_total;
    logic               r_motion_en;
    logic [IDX_W-1:0]   r_last_entry;

    // move state
    logic [LEN_W-1:0]   r_move_time;
    logic [IDX_W-1:0]   r_sample_index;

    // working registers
    t_phase             r_phase;
    logic [V0_W-1:0]    r_v0;
    logic [LEN_W-1:0]   r_s;
    logic [IDX_W-1:0]   r_walk;
    logic [V0_W-1:0]    r_mul_a;
    logic [PROD_W-1:0]  r_mul_b;
    logic [PROD_W-1:0]  r_mul_acc;
    logic [PROD_W-1:0]  r_div_num;
    logic [REM_W-1:0]   r_div_rem;
    logic [DEN_W-1:0]   r_div_den;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // result word
    logic [IDX_W-1:0]   r_out_index;
    logic [LEN_W-1:0]   r_out_dist;
    t_phase             r_out_phase;
    logic [LEN_W-1:0]   r_out_time;

    logic [IDX_W-1:0]   in_index;
    logic [LEN_W-1:0]   in_length;
    logic [DT_W-1:0]    in_delta;
    logic [DEN_W-1:0]   total_eff;
    logic [LEN_W-1:0]   v0_den;
    logic [LEN_W-1:0]   decel_span;
    logic [REM_W-1:0]   rem_sh;
    logic               rem_ge;
    logic [LEN_W:0]     t_sum;
    logic [LEN_W-1:0]   t_new;
    logic [LEN_W-1:0]   sq_x;
    logic [CRX_W-1:0]   cruise_x;
    logic [PROD_W-FRAC_W-2:0] cruise_s;
    logic [PROD_W-FRAC_W-1:0] div_s;
    logic [LEN_W-1:0]   ram_rdata;

    assign in_index  = i_in_data[IDX_W-1:0];
    assign in_length = i_in_data[IDX_W +: LEN_W];
    assign in_delta  = i_in_data[IDX_W + LEN_W +: DT_W];

    assign total_eff  = (r_total == '0) ? DEN_W'(1) : r_total;
    assign v0_den     = {1'b0, r_decel_start} + ONE_Q - {1'b0, r_accel_end};
    assign decel_span = ONE_Q - {1'b0, r_decel_start};

    assign rem_sh = {r_div_rem[REM_W-2:0], r_div_num[PROD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_div_den});

    assign t_sum = {1'b0, r_move_time} + {1'b0, r_div_num[LEN_W-1:0]};
    always_comb begin
        t_new = r_move_time;
        if (r_motion_en && r_move_time < ONE_Q) begin
            if (r_div_num[PROD_W-1:LEN_W] != '0 || t_sum > {1'b0, ONE_Q}) begin
                t_new = ONE_Q;
            end else begin
                t_new = t_sum[LEN_W-1:0];
            end
        end
    end

    assign sq_x     = (r_phase == PH_ACCEL) ? r_move_time : (ONE_Q - r_move_time);
    assign cruise_x = {r_move_time, 1'b0} - {2'b00, r_accel_end};
    assign cruise_s = r_mul_acc[PROD_W-1:FRAC_W+1];
    assign div_s    = r_div_num[PROD_W-1:FRAC_W];

    eals_ram #(
        .WIDTH (LEN_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_op == OP_LOAD),
        .i_waddr (in_index),
        .i_wdata (in_length),
        .i_raddr (r_walk),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_end    <= 16'd16384;
            r_decel_start  <= 16'd49152;
            r_total        <= 24'd655360;
            r_motion_en    <= 1'b1;
            r_last_entry   <= IDX_W'(TABLE_DEPTH - 1);
            r_move_time    <= '0;
            r_sample_index <= '0;
            r_div_cnt      <= '0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_ACCEL_END:   r_accel_end   <= i_cfg_wdata[FRAC_W-1:0];
                    CFG_DECEL_START: r_decel_start <= i_cfg_wdata[FRAC_W-1:0];
                    CFG_TOTAL_TIME:  r_total       <= i_cfg_wdata[TOTAL_W-1:0];
                    CFG_MOTION_EN:   r_motion_en   <= i_cfg_wdata[0];
                    CFG_LAST_ENTRY:  r_last_entry  <= i_cfg_wdata[IDX_W-1:0];
                    default: ;
                endcase
            end
            case (i_op)
                OP_RESTART: begin
                    r_move_time    <= '0;
                    r_sample_index <= '0;
                end
                OP_TIME_UPDATE: begin
                    r_move_time <= t_new;
                end
                OP_DIV_INC_START, OP_DIV_V0_START, OP_DIV_S_START: begin
                    r_div_cnt <= DIV_ITER;
                end
                OP_DIV_STEP: begin
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
                OP_OUT_LOAD: begin
                    r_sample_index <= (r_phase == PH_DONE) ? '0 : r_walk;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_DIV_INC_START: begin
                r_div_num <= PROD_W'({in_delta, {FRAC_W{1'b0}}});
                r_div_den <= total_eff;
                r_div_rem <= '0;
            end
            OP_DIV_V0_START: begin
                r_div_num <= V0_NUM;
                r_div_den <= DEN_W'(v0_den);
                r_div_rem <= '0;
            end
            OP_DIV_S_START: begin
                r_div_num <= r_mul_acc;
                r_div_den <= (r_phase == PH_ACCEL) ? DEN_W'({r_accel_end, 1'b0})
                                                   : DEN_W'({decel_span, 1'b0});
                r_div_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_div_rem <= rem_ge ? (rem_sh - {1'b0, r_div_den}) : rem_sh;
                r_div_num <= {r_div_num[PROD_W-2:0], rem_ge};
            end
            OP_TIME_UPDATE: begin
                r_phase <= phase_of(t_new, r_accel_end, r_decel_start);
                r_s     <= ONE_Q;
            end
            OP_V0_TAKE: begin
                r_v0 <= (r_div_num > V0_CAP) ? V0_CAP[V0_W-1:0] : r_div_num[V0_W-1:0];
            end
            OP_MUL_SQ_START: begin
                r_mul_a   <= V0_W'(sq_x);
                r_mul_b   <= PROD_W'(sq_x);
                r_mul_acc <= '0;
            end
            OP_MUL_V_START: begin
                r_mul_a   <= r_v0;
                r_mul_b   <= (r_phase == PH_CRUISE) ? PROD_W'(cruise_x) : r_mul_acc;
                r_mul_acc <= '0;
            end
            OP_MUL_STEP: begin
                if (r_mul_a[0]) begin
                    r_mul_acc <= r_mul_acc + r_mul_b;
                end
                r_mul_a <= r_mul_a >> 1;
                r_mul_b <= r_mul_b << 1;
            end
            OP_S_CRUISE: begin
                r_s <= (cruise_s > (PROD_W-FRAC_W-1)'(ONE_Q)) ? ONE_Q : cruise_s[LEN_W-1:0];
            end
            OP_S_TAKE: begin
                if (r_phase == PH_ACCEL) begin
                    r_s <= (div_s > (PROD_W-FRAC_W)'(ONE_Q)) ? ONE_Q : div_s[LEN_W-1:0];
                end else begin
                    r_s <= (div_s >= (PROD_W-FRAC_W)'(ONE_Q)) ? '0
                                                              : ONE_Q - div_s[LEN_W-1:0];
                end
            end
            OP_WALK_INIT: begin
                r_walk <= (r_sample_index > r_last_entry) ? r_last_entry : r_sample_index;
            end
            OP_WALK_INC: begin
                r_walk <= r_walk + 1'b1;
            end
            OP_OUT_LOAD: begin
                r_out_index <= (r_phase == PH_DONE) ? '0 : r_walk;
                r_out_dist  <= r_s;
                r_out_phase <= r_phase;
                r_out_time  <= r_move_time;
            end
            default: ;
        endcase
    end

    assign o_stat.div_done   = (r_div_cnt == '0);
    assign o_stat.mul_done   = (r_mul_a == '0);
    assign o_stat.phase      = r_phase;
    assign o_stat.walk_more  = (r_walk < r_last_entry);
    assign o_stat.entry_lt_s = (ram_rdata < r_s);

    assign o_out_data = {{(OUT_DATA_W - IDX_W - 2 * LEN_W){1'b0}},
                         r_out_time, r_out_dist, r_out_index};
    assign o_out_user = r_out_phase;

    `EALS_ASSERT_NXT(a_time_bounded, i_op == OP_TIME_UPDATE, r_move_time <= ONE_Q)
    `EALS_ASSERT_NXT(a_walk_in_limit, i_op == OP_WALK_INC, r_walk <= r_last_entry)
    `EALS_ASSERT_NXT(a_done_rewinds, i_op == OP_OUT_LOAD && r_phase == PH_DONE, r_sample_index == '0)

endmodule

FILE: hw/rtl/ease_in_out_arc_length_stepper.sv
// tick: once the move is finished only the time divide runs, else up to three 64-step divides
// and two shift-add multiplies, then a walk of the arc length table
// load, restart and unused words are taken while idle; one word is worked at a time
// synchronous active-low reset: config registers to defaults, move time and index to zero
// the arc length table is not cleared and reads undefined until loaded
// depends on eals_pkg, eals_ctrl and eals_dp
module ease_in_out_arc_length_stepper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index, entry_length, elapsed time, zero pad
    input  logic [eals_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [eals_pkg::USER_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // point_index, distance, time_fraction, zero pad
    output logic [eals_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // phase
    output logic [eals_pkg::USER_W-1:0]      m_axis_tuser,
    input  logic                             i_cfg_wen,
    input  logic [eals_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [eals_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import eals_pkg::*;

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    eals_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_op        (dp_op),
        .i_stat      (dp_stat)
    );

    eals_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dp_op),
        .o_stat      (dp_stat),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule
